// ===== hw/rtl/rau_pkg.sv =====
`default_nettype none

package rau_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int MAG_W         = 64;
	localparam int CNT_W         = 6;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);
	localparam logic [MAG_W-1:0] POS_MAX  = {1'b0, {(MAG_W-1){1'b1}}};
	localparam logic [MAG_W-1:0] NEG_LIM  = {1'b1, {(MAG_W-1){1'b0}}};

	typedef logic [OPERAND_WIDTH-1:0] mag_t;

	typedef enum logic [2:0] {
		FUNC_ADD     = 3'd0,
		FUNC_SUB     = 3'd1,
		FUNC_MUL     = 3'd2,
		FUNC_DIV     = 3'd3,
		FUNC_MUL_INT = 3'd4,
		FUNC_DIV_INT = 3'd5,
		FUNC_REDUCE  = 3'd6
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_ADD,
		ST_ADD2,
		ST_SIGN,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_OUT
	} state_t;

	function automatic mag_t to_mag(input mag_t v);
		to_mag = v[OPERAND_WIDTH-1] ? (~v + mag_t'(1)) : v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
`default_nettype none

// Channel | Direction | Beat contents
// s       | in        | tuser: func[2:0]; tdata: a_num, a_den, b_num, b_den (32 bits each)
// m       | out       | tdata: res_num[63:0], res_den[126:64], zero_den_error[127],
//         |           |        overflow[128], zeros up to bit 135
//
// One item at a time: s_tready is high only while idle. An item runs up to three
// products on one 32x32 multiplier, a binary GCD (one compare/subtract, swap or shift
// a cycle) and two 64-step restoring divisions, all on one shared 65-bit adder. The
// result waits in the output register; a stalled m side holds the next result in the
// last step. arst_n clears control.

module rational_arithmetic_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [127:0] s_tdata,  // a_num, a_den, b_num, b_den
	input  wire [2:0]   s_tuser,  // func
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [135:0] m_tdata  // res_num, res_den, zero_den_error, overflow
);

	localparam int OW = rau_pkg::OPERAND_WIDTH;
	localparam int MW = rau_pkg::MAG_W;

	rau_pkg::state_t state_q, state_d;

	rau_pkg::func_t func_q;
	rau_pkg::mag_t  an_q, ad_q, bn_q, bd_q;
	logic           an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic           zerr_q;

	logic [MW-1:0]  num_q, t1_q, den_q;
	logic           num_neg_q, t1_neg_q, den_neg_q;

	logic [MW-1:0]  gx_q, gy_q, g_q, q_q, rem_q;
	logic [rau_pkg::CNT_W-1:0] gk_q, cnt_q;

	logic [MW-1:0]  res_num_q;
	logic [MW-2:0]  res_den_q;
	logic           res_zerr_q, res_ovf_q, m_tvalid_q;

	// shared units
	rau_pkg::mag_t  mul_a, mul_b;
	logic           mul_neg;
	logic [2*OW-1:0] mul_p;
	logic [MW:0]    alu_a, alu_b;
	logic           alu_sub;
	logic [MW+1:0]  alu_r;
	logic           borrow;

	logic           is_addsub, accept, out_load;
	rau_pkg::mag_t  in_an, in_ad, in_bn, in_bd, ad_mag, bd_mag;
	rau_pkg::func_t in_func;
	logic [MW-1:0]  q_nxt, rem_nxt, den_eff;
	logic           den_zero, ovf_c;
	logic [MW-1:0]  rn_c;

	assign mul_p = mul_a * mul_b;
	assign alu_r = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
	assign borrow = alu_r[MW+1];

	assign is_addsub = (func_q == rau_pkg::FUNC_ADD) || (func_q == rau_pkg::FUNC_SUB);
	assign accept    = s_tvalid && s_tready;
	assign out_load  = (state_q == rau_pkg::ST_OUT) && (!m_tvalid_q || m_tready);

	assign in_func = rau_pkg::func_t'(s_tuser);
	assign in_an   = s_tdata[OW-1:0];
	assign in_ad   = s_tdata[32 +: OW];
	assign in_bn   = s_tdata[64 +: OW];
	assign in_bd   = s_tdata[96 +: OW];
	assign ad_mag  = rau_pkg::to_mag(in_ad);
	assign bd_mag  = rau_pkg::to_mag(in_bd);

	assign q_nxt   = {q_q[MW-2:0], ~borrow};
	assign rem_nxt = borrow ? alu_a[MW-1:0] : alu_r[MW-1:0];

	assign den_zero = (den_q == '0);
	assign den_eff  = den_zero ? MW'(1) : den_q;

	always_comb begin
		if (num_neg_q) begin
			ovf_c = (num_q > rau_pkg::NEG_LIM);
			rn_c  = ovf_c ? rau_pkg::NEG_LIM : (~num_q + MW'(1));
		end else begin
			ovf_c = (num_q > rau_pkg::POS_MAX);
			rn_c  = ovf_c ? rau_pkg::POS_MAX : num_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rau_pkg::ST_IDLE: if (accept) state_d = rau_pkg::ST_MUL0;
			rau_pkg::ST_MUL0: state_d = is_addsub ? rau_pkg::ST_MUL1 : rau_pkg::ST_MUL2;
			rau_pkg::ST_MUL1: state_d = rau_pkg::ST_MUL2;
			rau_pkg::ST_MUL2: state_d = is_addsub ? rau_pkg::ST_ADD : rau_pkg::ST_SIGN;
			rau_pkg::ST_ADD:  state_d = (alu_sub && borrow) ? rau_pkg::ST_ADD2 : rau_pkg::ST_SIGN;
			rau_pkg::ST_ADD2: state_d = rau_pkg::ST_SIGN;
			rau_pkg::ST_SIGN: state_d = rau_pkg::ST_GCD;
			rau_pkg::ST_GCD:  if (gx_q == '0) state_d = rau_pkg::ST_DIVN;
			rau_pkg::ST_DIVN: if (cnt_q == rau_pkg::CNT_LAST) state_d = rau_pkg::ST_DIVD;
			rau_pkg::ST_DIVD: if (cnt_q == rau_pkg::CNT_LAST) state_d = rau_pkg::ST_OUT;
			rau_pkg::ST_OUT:  if (out_load) state_d = rau_pkg::ST_IDLE;
			default:          state_d = rau_pkg::ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		s_tready = 1'b0;
		mul_a    = an_q;
		mul_b    = rau_pkg::mag_t'(1);
		mul_neg  = an_neg_q;
		alu_a    = {1'b0, gx_q};
		alu_b    = {1'b0, gy_q};
		alu_sub  = 1'b1;
		unique case (state_q)
			rau_pkg::ST_IDLE: s_tready = 1'b1;
			rau_pkg::ST_MUL0: begin
				unique case (func_q)
					rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB, rau_pkg::FUNC_DIV: begin
						mul_b   = bd_q;
						mul_neg = an_neg_q ^ bd_neg_q;
					end
					rau_pkg::FUNC_MUL, rau_pkg::FUNC_MUL_INT: begin
						mul_b   = bn_q;
						mul_neg = an_neg_q ^ bn_neg_q;
					end
					default: ;
				endcase
			end
			rau_pkg::ST_MUL1: begin
				mul_a   = bn_q;
				mul_b   = ad_q;
				mul_neg = bn_neg_q ^ ad_neg_q ^ (func_q == rau_pkg::FUNC_SUB);
			end
			rau_pkg::ST_MUL2: begin
				mul_a   = ad_q;
				mul_neg = ad_neg_q;
				unique case (func_q)
					rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB, rau_pkg::FUNC_MUL: begin
						mul_b   = bd_q;
						mul_neg = ad_neg_q ^ bd_neg_q;
					end
					rau_pkg::FUNC_DIV, rau_pkg::FUNC_DIV_INT: begin
						mul_b   = bn_q;
						mul_neg = ad_neg_q ^ bn_neg_q;
					end
					default: ;
				endcase
			end
			rau_pkg::ST_ADD: begin
				alu_a   = {1'b0, num_q};
				alu_b   = {1'b0, t1_q};
				alu_sub = (num_neg_q != t1_neg_q);
			end
			rau_pkg::ST_ADD2: begin
				alu_a = {1'b0, t1_q};
				alu_b = {1'b0, num_q};
			end
			rau_pkg::ST_DIVN, rau_pkg::ST_DIVD: begin
				alu_a = {rem_q, q_q[MW-1]};
				alu_b = {1'b0, g_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rau_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rau_pkg::ST_IDLE: begin
				if (accept) begin
					func_q   <= in_func;
					an_q     <= rau_pkg::to_mag(in_an);
					an_neg_q <= in_an[OW-1];
					bn_q     <= rau_pkg::to_mag(in_bn);
					bn_neg_q <= in_bn[OW-1];
					ad_q     <= (ad_mag == '0) ? rau_pkg::mag_t'(1) : ad_mag;
					ad_neg_q <= in_ad[OW-1];
					bd_q     <= (bd_mag == '0) ? rau_pkg::mag_t'(1) : bd_mag;
					bd_neg_q <= in_bd[OW-1];
					zerr_q   <= (ad_mag == '0) ||
						((bd_mag == '0) && (in_func <= rau_pkg::FUNC_DIV));
				end
			end
			rau_pkg::ST_MUL0: begin
				num_q     <= MW'(mul_p);
				num_neg_q <= mul_neg;
			end
			rau_pkg::ST_MUL1: begin
				t1_q     <= MW'(mul_p);
				t1_neg_q <= mul_neg;
			end
			rau_pkg::ST_MUL2: begin
				den_q     <= MW'(mul_p);
				den_neg_q <= mul_neg;
			end
			rau_pkg::ST_ADD: begin
				// opposite signs with the second term larger: redo as t1 - num
				if (!(alu_sub && borrow)) num_q <= alu_r[MW-1:0];
			end
			rau_pkg::ST_ADD2: begin
				num_q     <= alu_r[MW-1:0];
				num_neg_q <= t1_neg_q;
			end
			rau_pkg::ST_SIGN: begin
				num_neg_q <= (num_q != '0) && (num_neg_q ^ (den_neg_q && !den_zero));
				zerr_q    <= zerr_q || den_zero;
				den_q     <= den_eff;
				gx_q      <= num_q;
				gy_q      <= den_eff;
				gk_q      <= '0;
			end
			rau_pkg::ST_GCD: begin
				priority if (gx_q == '0) begin
					g_q   <= gy_q << gk_q;
					q_q   <= num_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					gk_q <= gk_q + 1'b1;
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else if (borrow) begin
					// keep x >= y: swap, subtract next beat
					gx_q <= gy_q;
					gy_q <= gx_q;
				end else begin
					gx_q <= alu_r[MW-1:0];
				end
			end
			rau_pkg::ST_DIVN: begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rau_pkg::CNT_LAST) begin
					num_q <= q_nxt;
					q_q   <= den_q;
					rem_q <= '0;
				end else begin
					q_q   <= q_nxt;
					rem_q <= rem_nxt;
				end
			end
			rau_pkg::ST_DIVD: begin
				cnt_q <= cnt_q + 1'b1;
				q_q   <= q_nxt;
				rem_q <= rem_nxt;
				if (cnt_q == rau_pkg::CNT_LAST) den_q <= q_nxt;
			end
			rau_pkg::ST_OUT: begin
				if (out_load) begin
					res_num_q  <= rn_c;
					res_den_q  <= den_q[MW-2:0];
					res_zerr_q <= zerr_q;
					res_ovf_q  <= ovf_c;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, res_ovf_q, res_zerr_q, res_den_q, res_num_q};

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int NUM_RANDOM     = 1800;

	typedef struct packed {
		logic        ovf;
		logic        zerr;
		logic [62:0] den;
		logic [63:0] num;
	} frac_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;

	int  err_count;
	int  idle_cycles;
	int  phase;
	bit  stim_done;
	bit  hold_off;

	rational_arithmetic_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		err_count++;
	endtask

	// Sign-magnitude helpers at the 64-bit magnitude used by the block.
	function automatic logic [63:0] mag32(input logic [31:0] v);
		return v[31] ? {32'b0, (~v + 32'd1)} : {32'b0, v};
	endfunction

	function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic void sm_sum(input logic xn, input logic [63:0] xm,
			input logic yn, input logic [63:0] ym, output logic rn, output logic [63:0] rm);
		if (xn == yn) begin
			rn = xn; rm = xm + ym;
		end else if (xm >= ym) begin
			rn = xn; rm = xm - ym;
		end else begin
			rn = yn; rm = ym - xm;
		end
		if (rm == 0) rn = 1'b0;
	endfunction

	function automatic frac_result_t rational_result(input logic [2:0] op,
			input logic [31:0] an, input logic [31:0] ad,
			input logic [31:0] bn, input logic [31:0] bd);
		frac_result_t r;
		logic        ans, ads, bns, bds, ns, ds, ts1, ts2;
		logic [63:0] anm, adm, bnm, bdm, nm, dm, tm1, tm2, g;
		ans = an[31]; anm = mag32(an);
		ads = ad[31]; adm = mag32(ad);
		bns = bn[31]; bnm = mag32(bn);
		bds = bd[31]; bdm = mag32(bd);
		r = '0;
		if (adm == 0) begin
			adm = 1; ads = 1'b0; r.zerr = 1'b1;
		end
		if (op <= rau_pkg::FUNC_DIV && bdm == 0) begin
			bdm = 1; bds = 1'b0; r.zerr = 1'b1;
		end
		if (op == rau_pkg::FUNC_SUB) bns = ~bns;
		if (bnm == 0) bns = 1'b0;
		case (op)
			rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
				tm1 = anm * bdm; ts1 = (ans != bds) && tm1 != 0;
				tm2 = bnm * adm; ts2 = (bns != ads) && tm2 != 0;
				sm_sum(ts1, tm1, ts2, tm2, ns, nm);
				dm = adm * bdm; ds = ads != bds;
			end
			rau_pkg::FUNC_MUL: begin
				nm = anm * bnm; ns = ans != bns;
				dm = adm * bdm; ds = ads != bds;
			end
			rau_pkg::FUNC_DIV: begin
				nm = anm * bdm; ns = ans != bds;
				dm = adm * bnm; ds = ads != bns;
			end
			rau_pkg::FUNC_MUL_INT: begin
				nm = anm * bnm; ns = ans != bns;
				dm = adm; ds = ads;
			end
			rau_pkg::FUNC_DIV_INT: begin
				nm = anm; ns = ans;
				dm = adm * bnm; ds = ads != bns;
			end
			default: begin
				nm = anm; ns = ans;
				dm = adm; ds = ads;
			end
		endcase
		if (nm == 0) ns = 1'b0;
		if (dm == 0) begin
			dm = 1; ds = 1'b0; r.zerr = 1'b1;
		end
		ns = (ns != ds) && nm != 0;
		g = gcd64(nm, dm);
		if (g == 0) g = 1;
		nm = nm / g;
		dm = dm / g;
		if (ns) begin
			if (nm > rau_pkg::NEG_LIM) begin
				r.num = rau_pkg::NEG_LIM; r.ovf = 1'b1;
			end else begin
				r.num = -nm;
			end
		end else if (nm > rau_pkg::POS_MAX) begin
			r.num = rau_pkg::POS_MAX; r.ovf = 1'b1;
		end else begin
			r.num = nm;
		end
		r.den = dm[62:0];
		return r;
	endfunction

	class fraction_scoreboard;
		frac_result_t pending[$];

		function void note_operands(input logic [2:0] op, input logic [127:0] d);
			pending.push_back(rational_result(op, d[31:0], d[63:32], d[95:64], d[127:96]));
		endfunction

		task check_result(input logic [135:0] d);
			frac_result_t want;
			if (pending.size() == 0) begin
				report_mismatch("result beat with nothing expected");
				return;
			end
			want = pending.pop_front();
			if (d[63:0] !== want.num)
				report_mismatch($sformatf("res_num %h want %h", d[63:0], want.num));
			if (d[126:64] !== want.den)
				report_mismatch($sformatf("res_den %h want %h", d[126:64], want.den));
			if (d[127] !== want.zerr)
				report_mismatch($sformatf("zero_den_error %b want %b", d[127], want.zerr));
			if (d[128] !== want.ovf)
				report_mismatch($sformatf("overflow %b want %b", d[128], want.ovf));
			if (d[135:129] !== '0)
				report_mismatch("nonzero pad bits");
		endtask
	endclass

	fraction_scoreboard fsb;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sample both sides at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				fsb.note_operands(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				fsb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: random stall by phase, with a long hold-off on request.
	initial begin
		int hold;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				for (hold = 0; hold < 3000; hold++) @(negedge clk);
				hold_off = 1'b0;
			end
			if (phase == 2)
				m_tready <= ($urandom_range(99) >= 76);
			else if (phase == 3)
				m_tready <= ($urandom_range(99) >= 20);
			else
				m_tready <= 1'b1;
		end
	end

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(0);
			3: return 32'($signed($urandom_range(20)) - 10);
			4: return 32'($urandom_range(1000));
			5: return -32'($urandom_range(1000));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [2:0] op, input logic [31:0] an,
			input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd);
		int idle_pct;
		idle_pct = (phase == 1) ? 76 : 20;
		if (phase == 1 || phase == 3) begin
			while ($urandom_range(99) < idle_pct) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {bd, bn, ad, an};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [31:0] mn, mx;
		int i;
		fsb = new();
		err_count = 0;
		idle_cycles = 0;
		phase = 0;
		hold_off = 1'b0;
		stim_done = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		mn = 32'h8000_0000;
		mx = 32'h7fff_ffff;

		// Directed corners: every op, zero denominators, division by zero,
		// zero numerator, unused code and extreme magnitudes.
		send_item(rau_pkg::FUNC_ADD, 1, 2, 1, 3);
		send_item(rau_pkg::FUNC_SUB, 1, 2, 1, 2);
		send_item(rau_pkg::FUNC_MUL, 6, -4, 10, 9);
		send_item(rau_pkg::FUNC_DIV, 3, 4, -6, 8);
		send_item(rau_pkg::FUNC_MUL_INT, 5, 12, -3, 0);
		send_item(rau_pkg::FUNC_DIV_INT, 5, 12, 10, 0);
		send_item(rau_pkg::FUNC_REDUCE, -12, -18, 0, 0);
		send_item(3'd7, 100, -75, 0, 0);
		send_item(rau_pkg::FUNC_ADD, 7, 0, 1, 0);
		send_item(rau_pkg::FUNC_DIV, 7, 3, 0, 5);
		send_item(rau_pkg::FUNC_DIV_INT, -7, 3, 0, 5);
		send_item(rau_pkg::FUNC_MUL, 0, 5, 9, 7);
		send_item(rau_pkg::FUNC_MUL, mn, 1, mn, 1);
		send_item(rau_pkg::FUNC_MUL, mn, -1, mn, 1);
		send_item(rau_pkg::FUNC_ADD, mn, 1, mn, 1);
		send_item(rau_pkg::FUNC_SUB, mx, mn, mn, mx);
		send_item(rau_pkg::FUNC_ADD, mx, mx, mx, mn);
		send_item(rau_pkg::FUNC_MUL_INT, mn, -1, mn, mn);
		send_item(rau_pkg::FUNC_DIV, mn, mx, mn, mx);
		send_item(rau_pkg::FUNC_REDUCE, mn, mn, mn, mn);
		send_item(rau_pkg::FUNC_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff);

		for (phase = 0; phase < 4; phase++) begin
			if (phase == 2) hold_off = 1'b1;
			for (i = 0; i < NUM_RANDOM / 4; i++)
				send_item(3'($urandom_range(7)), rand_operand(), rand_operand(),
					rand_operand(), rand_operand());
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		int tail;
		wait (stim_done);
		tail = 0;
		while (fsb.pending.size() != 0 && tail < 200000) begin
			@(posedge clk);
			tail++;
		end
		repeat (600) @(posedge clk);
		if (err_count == 0 && fsb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== rational_arithmetic_unit.f =====
hw/rtl/rau_pkg.sv
hw/rtl/rational_arithmetic_unit.sv
bench/tb_top.sv
